FILE: sv/assert_macros.svh
// Assertion helpers shared by the RTL. Every check is clocked on clk_i and
// is held off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge.
`define SMM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// When the trigger holds, the consequence must hold in the next cycle.
`define SMM_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/smm_pkg.sv
package smm_pkg;

  localparam int MAX_SIZE_DEF      = 32;
  localparam int ELEMENT_WIDTH_DEF = 16;
  localparam int MAX_RESULTS       = 32;

  localparam int FUNC_W  = 2;
  localparam int IDX_W   = 5;
  localparam int VALUE_W = 16;
  localparam int SUM_W   = 40;
  localparam int CFG_W   = 6;

  localparam logic [CFG_W-1:0] SIZE_RESET = CFG_W'(32);

  localparam logic [FUNC_W-1:0] FUNC_WR_A = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_WR_B = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_ROW  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_LOAD
  } ctrl_state_e;

  typedef struct packed {
    logic             wr_a;
    logic             wr_b;
    logic             issue;
    logic             clear_acc;
    logic             load_out;
    logic             last;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] j;
    logic [IDX_W-1:0] k;
  } cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic out_free;
  } status_t;

endpackage

FILE: sv/square_matrix_multiply.sv
// Channel  Direction  Handshake                  Payload
// in       input      in_valid_i / in_ready_o    func_i, row_i, col_i, value_i
// out      output     out_valid_o / out_ready_i  out_row_o, out_col_o, product_sum_o, last_o
// cfg      input      cfg_wr_en_i                cfg_wr_data_i (size_in_use)
//
// Each of the n results of a row request needs n reads through the single port of
// each store into one multiply-accumulate unit, a pipeline drain and one load.
// Reset clears the control state and sets the size to 32; the stores hold
// nothing defined until written. A stalled output holds the result register,
// and the next result waits in the accumulator until that transaction completes.
module square_matrix_multiply import smm_pkg::*; #(
  parameter int MAX_SIZE      = MAX_SIZE_DEF,
  parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [FUNC_W-1:0]         func_i,
  input  logic [IDX_W-1:0]          row_i,
  input  logic [IDX_W-1:0]          col_i,
  input  logic signed [VALUE_W-1:0] value_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [IDX_W-1:0]          out_row_o,
  output logic [IDX_W-1:0]          out_col_o,
  output logic signed [SUM_W-1:0]   product_sum_o,
  output logic                      last_o,
  input  logic                      cfg_wr_en_i,
  input  logic [CFG_W-1:0]          cfg_wr_data_i
);

  cmd_t    cmd;
  status_t status;

  smm_ctrl #(.MAX_SIZE(MAX_SIZE)) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .func_i        (func_i),
    .row_i         (row_i),
    .col_i         (col_i),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  smm_datapath #(.MAX_SIZE(MAX_SIZE), .ELEMENT_WIDTH(ELEMENT_WIDTH)) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .row_i         (row_i),
    .col_i         (col_i),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_row_o     (out_row_o),
    .out_col_o     (out_col_o),
    .product_sum_o (product_sum_o),
    .last_o        (last_o)
  );

endmodule

FILE: sv/smm_ram.sv
module smm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/smm_ctrl.sv
`include "assert_macros.svh"

module smm_ctrl import smm_pkg::*; #(
  parameter int MAX_SIZE = MAX_SIZE_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [FUNC_W-1:0] func_i,
  input  logic [IDX_W-1:0]  row_i,
  input  logic [IDX_W-1:0]  col_i,
  input  logic              cfg_wr_en_i,
  input  logic [CFG_W-1:0]  cfg_wr_data_i,
  input  status_t           status_i,
  output cmd_t              cmd_o
);

  localparam int LIMIT = (MAX_SIZE < MAX_RESULTS) ? MAX_SIZE : MAX_RESULTS;

  ctrl_state_e      state_q, state_d;
  logic [CFG_W-1:0] size_q;
  logic [CFG_W-1:0] n_eff;
  logic [CFG_W-1:0] n_q;
  logic [IDX_W-1:0] row_q, j_q, k_q;
  logic             accept;
  logic             start;
  logic             in_range;
  logic             k_last;
  logic             j_last;

  always_comb begin
    if (size_q == '0) begin
      n_eff = CFG_W'(1);
    end else if (int'(size_q) > LIMIT) begin
      n_eff = CFG_W'(LIMIT);
    end else begin
      n_eff = size_q;
    end
  end

  assign accept   = in_valid_i && in_ready_o;
  assign in_range = (int'(row_i) < MAX_SIZE) && (int'(col_i) < MAX_SIZE);
  assign start    = accept && (func_i == FUNC_ROW) && ({1'b0, row_i} < n_eff);
  assign k_last   = (k_q == IDX_W'(n_q - CFG_W'(1)));
  assign j_last   = (j_q == IDX_W'(n_q - CFG_W'(1)));

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (k_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!status_i.pipe_busy) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (status_i.out_free) begin
          state_d = j_last ? ST_IDLE : ST_ISSUE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready_o      = (state_q == ST_IDLE);
    cmd_o.wr_a      = accept && (func_i == FUNC_WR_A) && in_range;
    cmd_o.wr_b      = accept && (func_i == FUNC_WR_B) && in_range;
    cmd_o.issue     = (state_q == ST_ISSUE);
    cmd_o.clear_acc = (state_q == ST_ISSUE) && (k_q == '0);
    cmd_o.load_out  = (state_q == ST_LOAD) && status_i.out_free;
    cmd_o.last      = j_last;
    cmd_o.row       = row_q;
    cmd_o.j         = j_q;
    cmd_o.k         = k_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      size_q  <= SIZE_RESET;
      n_q     <= SIZE_RESET;
      row_q   <= '0;
      j_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_wr_en_i) begin
        size_q <= cfg_wr_data_i;
      end
      if (start) begin
        n_q   <= n_eff;
        row_q <= row_i;
        j_q   <= '0;
        k_q   <= '0;
      end
      if (state_q == ST_ISSUE) begin
        k_q <= k_last ? '0 : k_q + IDX_W'(1);
      end
      if (cmd_o.load_out && !j_last) begin
        j_q <= j_q + IDX_W'(1);
      end
    end
  end

  `SMM_ASSERT(a_issue_in_range, !cmd_o.issue || ({1'b0, k_q} < n_q), "inner index past size")
  `SMM_ASSERT_NEXT(a_last_returns_idle, cmd_o.load_out && cmd_o.last, in_ready_o,
                   "row finished but input not ready")

endmodule

FILE: sv/smm_datapath.sv
`include "assert_macros.svh"

module smm_datapath import smm_pkg::*; #(
  parameter int MAX_SIZE      = MAX_SIZE_DEF,
  parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cmd_t                      cmd_i,
  output status_t                   status_o,
  input  logic [IDX_W-1:0]          row_i,
  input  logic [IDX_W-1:0]          col_i,
  input  logic signed [VALUE_W-1:0] value_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [IDX_W-1:0]          out_row_o,
  output logic [IDX_W-1:0]          out_col_o,
  output logic signed [SUM_W-1:0]   product_sum_o,
  output logic                      last_o
);

  localparam int DEPTH = MAX_SIZE * MAX_SIZE;
  localparam int AW    = $clog2(DEPTH);
  localparam int EW    = ELEMENT_WIDTH;

  logic [AW-1:0]              wr_addr, rd_addr_a, rd_addr_b, addr_a, addr_b;
  logic signed [EW-1:0]       elem;
  logic signed [EW-1:0]       a_rdata, b_rdata;
  logic                       v1_q, v2_q;
  logic signed [2*EW-1:0]     prod_q;
  logic signed [SUM_W-1:0]    acc_q;
  logic                       out_valid_q;
  logic [IDX_W-1:0]           out_row_q, out_col_q;
  logic signed [SUM_W-1:0]    out_sum_q;
  logic                       out_last_q;

  // Narrow or widen the Q1.15 input to the stored element width.
  assign elem = EW'(value_i);

  assign wr_addr   = AW'(int'(row_i) * MAX_SIZE + int'(col_i));
  assign rd_addr_a = AW'(int'(cmd_i.row) * MAX_SIZE + int'(cmd_i.k));
  assign rd_addr_b = AW'(int'(cmd_i.k) * MAX_SIZE + int'(cmd_i.j));
  assign addr_a    = cmd_i.wr_a ? wr_addr : rd_addr_a;
  assign addr_b    = cmd_i.wr_b ? wr_addr : rd_addr_b;

  smm_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_a),
    .addr_i  (addr_a),
    .wdata_i (elem),
    .rdata_o (a_rdata)
  );

  smm_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_b),
    .addr_i  (addr_b),
    .wdata_i (elem),
    .rdata_o (b_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.issue;
      v2_q <= v1_q;
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // The sum wraps modulo 2^40; products are sign-extended or cut to that width.
  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      prod_q <= a_rdata * b_rdata;
    end
    if (cmd_i.clear_acc) begin
      acc_q <= '0;
    end else if (v2_q) begin
      acc_q <= acc_q + SUM_W'(prod_q);
    end
    if (cmd_i.load_out) begin
      out_row_q  <= cmd_i.row;
      out_col_q  <= cmd_i.j;
      out_sum_q  <= acc_q;
      out_last_q <= cmd_i.last;
    end
  end

  assign status_o.pipe_busy = v1_q || v2_q;
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign out_row_o     = out_row_q;
  assign out_col_o     = out_col_q;
  assign product_sum_o = out_sum_q;
  assign last_o        = out_last_q;

  `SMM_ASSERT(a_load_after_drain, !cmd_i.load_out || (!v1_q && !v2_q),
              "result loaded before the products were summed")

endmodule
